// ===== sv/pw2d_pkg.sv =====
// ----------------------------------------------------------------------------
// pw2d_pkg
// shared constants, codes and types of the 2d piecewise-constant sampler
// ----------------------------------------------------------------------------
`default_nettype none

package pw2d_pkg;

  localparam int COLS        = 64;
  localparam int ROWS        = 32;
  localparam int WEIGHT_BITS = 16;
  localparam int FRAC_BITS   = 24;

  localparam int COL_W   = $clog2(COLS);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int ADDR_W  = COL_W + ROW_W;
  localparam int CELLS   = COLS * ROWS;
  localparam int IDX_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int SUM_W   = WEIGHT_BITS + COL_W;
  localparam int TOT_W   = SUM_W + ROW_W;
  localparam int NUM_W   = TOT_W;
  localparam int DVD_W   = NUM_W + FRAC_BITS;
  localparam int DCNT_W  = $clog2(DVD_W + 1);
  localparam int DENS_W  = 32;
  localparam int DENS_FB = 16;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_BUILD  = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_BSUM_A, S_BSUM_B,
    S_BCDF_A, S_BCDF_B, S_BCDF_W,
    S_BMAR_A, S_BMAR_B, S_BMAR_W,
    S_SR_CHK, S_SR_CMP,
    S_C0_A, S_C0_B, S_C1_A, S_C1_B,
    S_FR, S_FR_W, S_COORD,
    S_W_A, S_W_B, S_D_W,
    S_OUT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [TOT_W-1:0]  den;
    logic              frac16;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DENS_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== sv/piecewise_2d_importance_sampler_core.sv =====
// ----------------------------------------------------------------------------
// piecewise_2d_importance_sampler_core
// samples a 2d piecewise-constant distribution from weight, row cdf and
// marginal cdf memories; load, build, sample and density query items
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  input    | in_valid, in_stall  | op, load_col, load_row, weight, unit_x,
//           |                     | unit_y
//  output   | out_valid, out_stall| sample_x, sample_y, cell_col, cell_row,
//           |                     | density, status
//
//  one item at a time; each divide holds the shared 51-step serial divider
//  synchronous reset clears control, total sum and the built flag; the
//  memories hold nothing defined until written
//  a waiting result blocks only the next item's own result, not its accept
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_2d_importance_sampler_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  op,
  input  wire logic [5:0]  load_col,
  input  wire logic [4:0]  load_row,
  input  wire logic [15:0] weight,
  input  wire logic [23:0] unit_x,
  input  wire logic [23:0] unit_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [23:0]      sample_x,
  output logic [23:0]      sample_y,
  output logic [5:0]       cell_col,
  output logic [4:0]       cell_row,
  output logic [31:0]      density,
  output logic             status
);

  localparam int FB = pw2d_pkg::FRAC_BITS;

  // control registers
  pw2d_pkg::state_t state, state_next;
  logic built, built_next;
  logic [pw2d_pkg::COL_W-1:0] cnt, cnt_next;
  logic [pw2d_pkg::ROW_W-1:0] row_i, row_i_next;
  logic [pw2d_pkg::TOT_W-1:0] total, total_next;
  logic out_valid_next;

  // datapath registers
  logic [pw2d_pkg::TOT_W-1:0] acc, acc_next;
  logic [pw2d_pkg::SUM_W-1:0] rsum, rsum_next;
  logic [pw2d_pkg::IDX_W-1:0] lo, lo_next, hi, hi_next, mid, mid_next;
  logic pass, pass_next;
  logic [FB-1:0] u, u_next, c0, c0_next, frac, frac_next;
  logic [FB:0] c1, c1_next;
  logic [FB-1:0] ux_q, ux_q_next;
  logic [FB-1:0] res_x, res_x_next, res_y, res_y_next;
  logic [pw2d_pkg::COL_W-1:0] res_col, res_col_next;
  logic [pw2d_pkg::ROW_W-1:0] res_row, res_row_next;
  logic [pw2d_pkg::DENS_W-1:0] res_dens, res_dens_next;
  logic res_st, res_st_next;

  // memory ports; cdf entries carry one extra bit for a full-scale value
  logic w_we;
  logic [pw2d_pkg::ADDR_W-1:0] w_waddr, w_raddr;
  logic [pw2d_pkg::WEIGHT_BITS-1:0] w_rdata;
  logic cdf_we;
  logic [pw2d_pkg::ADDR_W-1:0] cdf_waddr, cdf_raddr;
  logic [FB:0] cdf_wdata, cdf_rdata;
  logic mar_we;
  logic [pw2d_pkg::ROW_W-1:0] mar_waddr, mar_raddr;
  logic [FB:0] mar_wdata, mar_rdata;
  logic rs_we;
  logic [pw2d_pkg::ROW_W-1:0] rs_raddr;
  logic [pw2d_pkg::SUM_W-1:0] rs_rdata;

  pw2d_pkg::div_req_t dv_req;
  pw2d_pkg::div_rsp_t dv_rsp;

  // combinational helpers
  logic accept;
  logic out_free;
  logic [pw2d_pkg::TOT_W-1:0] acc_w, acc_rs;
  logic [pw2d_pkg::IDX_W:0] mid_sum;
  logic [pw2d_pkg::IDX_W-1:0] n_last;
  logic [FB:0] srch_data;
  logic [FB:0] cdf_uni, mar_uni;
  logic [FB-1:0] fr;
  logic [pw2d_pkg::ROW_W+FB-1:0] coord_y;
  logic [pw2d_pkg::COL_W+FB-1:0] coord_x;

  assign in_stall = (state != pw2d_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign acc_w   = acc + pw2d_pkg::TOT_W'(w_rdata);
  assign acc_rs  = acc + pw2d_pkg::TOT_W'(rs_rdata);
  assign mid_sum = {1'b0, lo} + {1'b0, hi} + 1'b1;
  assign n_last  = pass ? pw2d_pkg::IDX_W'(pw2d_pkg::COLS - 1)
                        : pw2d_pkg::IDX_W'(pw2d_pkg::ROWS - 1);
  assign srch_data = pass ? cdf_rdata : mar_rdata;
  // uniform steps for an all-zero row or table
  assign cdf_uni = (FB+1)'({1'b0, cnt} + 1'b1) << (FB - pw2d_pkg::COL_W);
  assign mar_uni = (FB+1)'({1'b0, row_i} + 1'b1) << (FB - pw2d_pkg::ROW_W);
  assign fr      = (u >= c0) ? u - c0 : '0;
  // cell index above the fraction, divided by a power-of-two count
  assign coord_y = {lo[pw2d_pkg::ROW_W-1:0], frac};
  assign coord_x = {lo[pw2d_pkg::COL_W-1:0], frac};

  always_comb begin
    state_next     = state;
    built_next     = built;
    cnt_next       = cnt;
    row_i_next     = row_i;
    total_next     = total;
    acc_next       = acc;
    rsum_next      = rsum;
    lo_next        = lo;
    hi_next        = hi;
    mid_next       = mid;
    pass_next      = pass;
    u_next         = u;
    c0_next        = c0;
    c1_next        = c1;
    frac_next      = frac;
    ux_q_next      = ux_q;
    res_x_next     = res_x;
    res_y_next     = res_y;
    res_col_next   = res_col;
    res_row_next   = res_row;
    res_dens_next  = res_dens;
    res_st_next    = res_st;
    out_valid_next = out_valid && out_stall;

    w_we      = 1'b0;
    w_waddr   = {load_row, load_col};
    w_raddr   = {row_i, cnt};
    cdf_we    = 1'b0;
    cdf_waddr = {row_i, cnt};
    cdf_wdata = dv_rsp.quot[FB:0];
    mar_we    = 1'b0;
    mar_waddr = row_i;
    mar_wdata = dv_rsp.quot[FB:0];
    rs_we     = 1'b0;
    rs_raddr  = row_i;
    dv_req    = '{start: 1'b0, num: acc_w, den: pw2d_pkg::TOT_W'(rsum), frac16: 1'b0};

    unique case (state)
      pw2d_pkg::S_IDLE: begin
        if (accept) begin
          res_x_next    = '0;
          res_y_next    = '0;
          res_col_next  = '0;
          res_row_next  = '0;
          res_dens_next = '0;
          res_st_next   = 1'b0;
          ux_q_next     = unit_x;
          cnt_next      = '0;
          row_i_next    = '0;
          acc_next      = '0;
          unique case (pw2d_pkg::op_t'(op))
            pw2d_pkg::OP_LOAD: begin
              w_we       = 1'b1;
              built_next = 1'b0;
              state_next = pw2d_pkg::S_OUT;
            end
            pw2d_pkg::OP_BUILD: begin
              total_next = '0;
              built_next = 1'b0;
              state_next = pw2d_pkg::S_BSUM_A;
            end
            pw2d_pkg::OP_SAMPLE: begin
              if (!built) begin
                res_st_next = 1'b1;
                state_next  = pw2d_pkg::S_OUT;
              end else begin
                pass_next  = 1'b0;
                u_next     = unit_y;
                lo_next    = '0;
                hi_next    = pw2d_pkg::IDX_W'(pw2d_pkg::ROWS - 1);
                state_next = pw2d_pkg::S_SR_CHK;
              end
            end
            pw2d_pkg::OP_QUERY: begin
              if (!built) begin
                res_st_next = 1'b1;
                state_next  = pw2d_pkg::S_OUT;
              end else begin
                res_col_next = unit_x[FB-1 -: pw2d_pkg::COL_W];
                res_row_next = unit_y[FB-1 -: pw2d_pkg::ROW_W];
                state_next   = pw2d_pkg::S_W_A;
              end
            end
            default: state_next = pw2d_pkg::S_IDLE;
          endcase
        end
      end

      // row sum pass
      pw2d_pkg::S_BSUM_A: state_next = pw2d_pkg::S_BSUM_B;
      pw2d_pkg::S_BSUM_B: begin
        if (cnt == pw2d_pkg::COL_W'(pw2d_pkg::COLS - 1)) begin
          rs_we      = 1'b1;
          rsum_next  = acc_w[pw2d_pkg::SUM_W-1:0];
          total_next = total + acc_w;
          acc_next   = '0;
          cnt_next   = '0;
          state_next = pw2d_pkg::S_BCDF_A;
        end else begin
          acc_next   = acc_w;
          cnt_next   = cnt + 1'b1;
          state_next = pw2d_pkg::S_BSUM_A;
        end
      end

      // row cdf pass
      pw2d_pkg::S_BCDF_A: state_next = pw2d_pkg::S_BCDF_B;
      pw2d_pkg::S_BCDF_B, pw2d_pkg::S_BCDF_W: begin
        if (state == pw2d_pkg::S_BCDF_B) begin
          acc_next = acc_w;
        end
        if (state == pw2d_pkg::S_BCDF_B && rsum != '0) begin
          dv_req.start = 1'b1;
          state_next   = pw2d_pkg::S_BCDF_W;
        end else if (state == pw2d_pkg::S_BCDF_B || dv_rsp.done) begin
          cdf_we    = 1'b1;
          cdf_wdata = (rsum == '0) ? cdf_uni : dv_rsp.quot[FB:0];
          if (cnt == pw2d_pkg::COL_W'(pw2d_pkg::COLS - 1)) begin
            cnt_next = '0;
            acc_next = '0;
            if (row_i == pw2d_pkg::ROW_W'(pw2d_pkg::ROWS - 1)) begin
              row_i_next = '0;
              state_next = pw2d_pkg::S_BMAR_A;
            end else begin
              row_i_next = row_i + 1'b1;
              state_next = pw2d_pkg::S_BSUM_A;
            end
          end else begin
            cnt_next   = cnt + 1'b1;
            state_next = pw2d_pkg::S_BCDF_A;
          end
        end
      end

      // marginal cdf pass over the row sums
      pw2d_pkg::S_BMAR_A: state_next = pw2d_pkg::S_BMAR_B;
      pw2d_pkg::S_BMAR_B, pw2d_pkg::S_BMAR_W: begin
        dv_req.num = acc_rs;
        dv_req.den = total;
        if (state == pw2d_pkg::S_BMAR_B) begin
          acc_next = acc_rs;
        end
        if (state == pw2d_pkg::S_BMAR_B && total != '0) begin
          dv_req.start = 1'b1;
          state_next   = pw2d_pkg::S_BMAR_W;
        end else if (state == pw2d_pkg::S_BMAR_B || dv_rsp.done) begin
          mar_we    = 1'b1;
          mar_wdata = (total == '0) ? mar_uni : dv_rsp.quot[FB:0];
          if (row_i == pw2d_pkg::ROW_W'(pw2d_pkg::ROWS - 1)) begin
            built_next = 1'b1;
            state_next = pw2d_pkg::S_OUT;
          end else begin
            row_i_next = row_i + 1'b1;
            state_next = pw2d_pkg::S_BMAR_A;
          end
        end
      end

      // binary search, each probe a check state then a compare state
      pw2d_pkg::S_SR_CHK: begin
        if (lo < hi) begin
          mid_next   = mid_sum[pw2d_pkg::IDX_W:1];
          state_next = pw2d_pkg::S_SR_CMP;
        end else begin
          state_next = pw2d_pkg::S_C0_A;
        end
      end
      pw2d_pkg::S_SR_CMP: begin
        if (srch_data <= {1'b0, u}) begin
          lo_next = mid;
        end else begin
          hi_next = mid - 1'b1;
        end
        state_next = pw2d_pkg::S_SR_CHK;
      end

      // cdf bounds of the chosen cell
      pw2d_pkg::S_C0_A: begin
        mid_next = lo;
        if (lo == '0) begin
          c0_next    = '0;
          state_next = pw2d_pkg::S_C1_A;
        end else begin
          state_next = pw2d_pkg::S_C0_B;
        end
      end
      pw2d_pkg::S_C0_B: begin
        // the chosen start never exceeds u, so it fits the unit width
        c0_next    = srch_data[FB-1:0];
        state_next = pw2d_pkg::S_C1_A;
      end
      pw2d_pkg::S_C1_A: begin
        mid_next = lo + 1'b1;
        if (lo == n_last) begin
          c1_next    = (FB+1)'(1) << FB;
          state_next = pw2d_pkg::S_FR;
        end else begin
          state_next = pw2d_pkg::S_C1_B;
        end
      end
      pw2d_pkg::S_C1_B: begin
        c1_next    = srch_data;
        state_next = pw2d_pkg::S_FR;
      end
      pw2d_pkg::S_FR: begin
        dv_req.num = pw2d_pkg::NUM_W'(fr);
        dv_req.den = pw2d_pkg::TOT_W'(c1 - {1'b0, c0});
        if (c1 > {1'b0, c0}) begin
          dv_req.start = 1'b1;
          state_next   = pw2d_pkg::S_FR_W;
        end else begin
          frac_next  = fr;
          state_next = pw2d_pkg::S_COORD;
        end
      end
      pw2d_pkg::S_FR_W: begin
        if (dv_rsp.done) begin
          frac_next  = dv_rsp.quot[FB-1:0];
          state_next = pw2d_pkg::S_COORD;
        end
      end
      pw2d_pkg::S_COORD: begin
        if (!pass) begin
          res_y_next   = coord_y[pw2d_pkg::ROW_W+FB-1:pw2d_pkg::ROW_W];
          res_row_next = lo[pw2d_pkg::ROW_W-1:0];
          pass_next    = 1'b1;
          u_next       = ux_q;
          lo_next      = '0;
          hi_next      = pw2d_pkg::IDX_W'(pw2d_pkg::COLS - 1);
          state_next   = pw2d_pkg::S_SR_CHK;
        end else begin
          res_x_next   = coord_x[pw2d_pkg::COL_W+FB-1:pw2d_pkg::COL_W];
          res_col_next = lo[pw2d_pkg::COL_W-1:0];
          state_next   = pw2d_pkg::S_W_A;
        end
      end

      // density of the chosen cell
      pw2d_pkg::S_W_A: begin
        w_raddr    = {res_row, res_col};
        state_next = pw2d_pkg::S_W_B;
      end
      pw2d_pkg::S_W_B: begin
        dv_req.num    = {w_rdata, {pw2d_pkg::ADDR_W{1'b0}}};
        dv_req.den    = total;
        dv_req.frac16 = 1'b1;
        if (total == '0) begin
          res_dens_next = '0;
          state_next    = pw2d_pkg::S_OUT;
        end else begin
          dv_req.start = 1'b1;
          state_next   = pw2d_pkg::S_D_W;
        end
      end
      pw2d_pkg::S_D_W: begin
        if (dv_rsp.done) begin
          res_dens_next = dv_rsp.quot;
          state_next    = pw2d_pkg::S_OUT;
        end
      end

      // hand the result to the output register
      pw2d_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          state_next     = pw2d_pkg::S_IDLE;
        end
      end

      default: state_next = pw2d_pkg::S_IDLE;
    endcase

    // cdf reads follow the probe index being registered, data on the registered read port in the following cycle
    cdf_raddr = {res_row, mid_next - 1'b1};
    mar_raddr = pw2d_pkg::ROW_W'(mid_next - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pw2d_pkg::S_IDLE;
      built     <= 1'b0;
      total     <= '0;
      out_valid <= 1'b0;
      cnt       <= '0;
      row_i     <= '0;
    end else begin
      state     <= state_next;
      built     <= built_next;
      total     <= total_next;
      out_valid <= out_valid_next;
      cnt       <= cnt_next;
      row_i     <= row_i_next;
    end
  end

  always_ff @(posedge clk) begin
    acc      <= acc_next;
    rsum     <= rsum_next;
    lo       <= lo_next;
    hi       <= hi_next;
    mid      <= mid_next;
    pass     <= pass_next;
    u        <= u_next;
    c0       <= c0_next;
    c1       <= c1_next;
    frac     <= frac_next;
    ux_q     <= ux_q_next;
    res_x    <= res_x_next;
    res_y    <= res_y_next;
    res_col  <= res_col_next;
    res_row  <= res_row_next;
    res_dens <= res_dens_next;
    res_st   <= res_st_next;
    if (state == pw2d_pkg::S_OUT && out_free) begin
      sample_x <= res_x;
      sample_y <= res_y;
      cell_col <= res_col;
      cell_row <= res_row;
      density  <= res_dens;
      status   <= res_st;
    end
  end

  // weights, one entry per cell
  pw2d_ram #(.WIDTH(pw2d_pkg::WEIGHT_BITS), .DEPTH(pw2d_pkg::CELLS)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (weight),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  // row cdfs, entry c holds cdf[c+1]; cdf[0] is zero and cdf[cols] is one
  pw2d_ram #(.WIDTH(FB+1), .DEPTH(pw2d_pkg::CELLS)) u_cdf_ram (
    .clk   (clk),
    .we    (cdf_we),
    .waddr (cdf_waddr),
    .wdata (cdf_wdata),
    .raddr (cdf_raddr),
    .rdata (cdf_rdata)
  );

  // marginal cdf, same layout over rows
  pw2d_ram #(.WIDTH(FB+1), .DEPTH(pw2d_pkg::ROWS)) u_mar_ram (
    .clk   (clk),
    .we    (mar_we),
    .waddr (mar_waddr),
    .wdata (mar_wdata),
    .raddr (mar_raddr),
    .rdata (mar_rdata)
  );

  pw2d_ram #(.WIDTH(pw2d_pkg::SUM_W), .DEPTH(pw2d_pkg::ROWS)) u_rowsum_ram (
    .clk   (clk),
    .we    (rs_we),
    .waddr (row_i),
    .wdata (acc_w[pw2d_pkg::SUM_W-1:0]),
    .raddr (rs_raddr),
    .rdata (rs_rdata)
  );

  pw2d_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dv_req),
    .rsp (dv_rsp)
  );

`ifndef SYNTHESIS
  // tables are only rewritten while the built flag is down
  a_cdf_write_unbuilt: assert property (@(posedge clk) disable iff (rst)
    (cdf_we || mar_we) |-> !built)
    else $error("cdf written while tables marked built");

  // a not-built report carries no coordinates or density
  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (sample_x == '0 && sample_y == '0 && density == '0))
    else $error("status result with nonzero payload");

  // a free output slot always takes the pending result
  a_out_handoff: assert property (@(posedge clk) disable iff (rst)
    (state == pw2d_pkg::S_OUT && !out_valid) |=> (out_valid && state == pw2d_pkg::S_IDLE))
    else $error("result not handed to output register");

  // the divider is never restarted before it answers
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    dv_req.start |=> (state == pw2d_pkg::S_BCDF_W || state == pw2d_pkg::S_BMAR_W ||
                      state == pw2d_pkg::S_FR_W || state == pw2d_pkg::S_D_W))
    else $error("divider started outside a wait state");
`endif

endmodule

`default_nettype wire

// ===== sv/pw2d_ram.sv =====
// ----------------------------------------------------------------------------
// pw2d_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module pw2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/pw2d_div.sv =====
// ----------------------------------------------------------------------------
// pw2d_div
// bit-serial restoring divider, floor(num * 2^k / den), k of 24 or 16
// ----------------------------------------------------------------------------
`default_nettype none

module pw2d_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pw2d_pkg::div_req_t req,
  output pw2d_pkg::div_rsp_t      rsp
);

  logic [pw2d_pkg::DCNT_W-1:0] cnt;
  logic [pw2d_pkg::DVD_W-1:0]  dvd;
  logic [pw2d_pkg::TOT_W-1:0]  rem;
  logic [pw2d_pkg::TOT_W-1:0]  den;
  logic [pw2d_pkg::DENS_W-1:0] quot;
  logic                        sat;
  logic                        done;
  logic [pw2d_pkg::TOT_W:0]    r2;
  logic                        ge;

  assign r2 = {rem, dvd[pw2d_pkg::DVD_W-1]};
  assign ge = (r2 >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= pw2d_pkg::DCNT_W'(pw2d_pkg::DVD_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == pw2d_pkg::DCNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      if (req.frac16) begin
        dvd <= pw2d_pkg::DVD_W'({req.num, {pw2d_pkg::DENS_FB{1'b0}}});
      end else begin
        dvd <= {req.num, {pw2d_pkg::FRAC_BITS{1'b0}}};
      end
      den  <= req.den;
      rem  <= '0;
      quot <= '0;
      sat  <= 1'b0;
    end else if (cnt != '0) begin
      dvd  <= {dvd[pw2d_pkg::DVD_W-2:0], 1'b0};
      rem  <= ge ? pw2d_pkg::TOT_W'(r2 - {1'b0, den}) : r2[pw2d_pkg::TOT_W-1:0];
      quot <= {quot[pw2d_pkg::DENS_W-2:0], ge};
      sat  <= sat | quot[pw2d_pkg::DENS_W-1];
    end
  end

  // saturate once a quotient bit falls off the top
  assign rsp.done = done;
  assign rsp.quot = sat ? '1 : quot;

endmodule

`default_nettype wire
